### hdl/shp_pkg.sv
// ----------------------------------------------------------------------------
// shp_pkg
// Types and constants shared by the socks header parser modules.
// ----------------------------------------------------------------------------
package shp_pkg;

  localparam logic [7:0] SocksVersion = 8'd5;
  localparam logic [7:0] AtypIpv4     = 8'd1;
  localparam logic [7:0] AtypDomain   = 8'd3;
  localparam logic [7:0] AtypIpv6     = 8'd4;
  localparam logic [7:0] Ipv4Len      = 8'd4;
  localparam logic [7:0] Ipv6Len      = 8'd16;

  localparam logic [1:0] KIND_ADDR   = 2'd0;
  localparam logic [1:0] KIND_ACCEPT = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;

  localparam logic CAUSE_VERSION   = 1'b0;
  localparam logic CAUSE_EARLY_END = 1'b1;

  localparam logic HDR_REQUEST = 1'b0;

  typedef enum logic [8:0] {
    PH_H0   = 9'b0_0000_0001,
    PH_H1   = 9'b0_0000_0010,
    PH_H2   = 9'b0_0000_0100,
    PH_TYPE = 9'b0_0000_1000,
    PH_DLEN = 9'b0_0001_0000,
    PH_ADDR = 9'b0_0010_0000,
    PH_PHI  = 9'b0_0100_0000,
    PH_PLO  = 9'b0_1000_0000,
    PH_SKIP = 9'b1_0000_0000
  } phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_packet;
  } shp_in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  address_byte;
    logic [7:0]  address_index;
    logic [7:0]  command_or_fragment;
    logic [7:0]  address_type;
    logic [7:0]  address_count;
    logic [15:0] port_number;
    logic [15:0] reserved_field;
    logic        reject_cause;
  } shp_out_t;

  typedef struct packed {
    logic     valid;
    shp_out_t data;
  } shp_res_t;

  typedef struct packed {
    phase_e      phase;
    logic [7:0]  addr_remaining;
    logic [7:0]  addr_count;
    logic [7:0]  held_type;
    logic [7:0]  held_command;
    logic [15:0] held_reserved;
    logic [7:0]  port_high;
  } shp_state_t;

  localparam shp_state_t ST_START = '{PH_H0, 8'd0, 8'd0, 8'd0, 8'd0, 16'd0, 8'd0};

endpackage

### hdl/socks_header_parser.sv
// ----------------------------------------------------------------------------
// socks_header_parser
// Byte-serial parser for request and datagram headers, streaming the address.
//
//   channel   direction  handshake                 payload
//   in        input      in_valid_i / in_stall_o   shp_in_t  (byte, end mark)
//   out       output     out_valid_o / out_stall_i shp_out_t (result)
//   cfg       input      cfg_we_i                  header kind bit
//
// one byte transaction per cycle while no stalled result blocks it; an accepted
// byte's result passes the input register, then the result register
// the phase machine sees each byte once, between the two registers
// reset clears both stages, the phase state and the header kind
// a stalled result holds the input register, which then stalls upstream
// ----------------------------------------------------------------------------
module socks_header_parser
  import shp_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  shp_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output shp_out_t out_data_o,
  input  logic     cfg_we_i,
  input  logic     cfg_wdata_i
);

  logic     in_vld;
  shp_in_t  in_item;
  logic     out_ready;
  logic     take;
  shp_res_t res;

  assign take = in_vld && out_ready;

  shp_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .take_i     (take),
    .valid_o    (in_vld),
    .data_o     (in_item)
  );

  shp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .take_i      (take),
    .item_i      (in_item),
    .res_o       (res)
  );

  shp_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (res),
    .ready_o     (out_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // upstream only waits behind a full, stalled result register
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_vld && out_valid_o && out_stall_i))
    else $error("input stalled without a blocked result");

  a_addr_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.kind == KIND_ADDR) |->
      (out_data_o.address_count == 8'd0 && out_data_o.port_number == 16'd0
       && out_data_o.reject_cause == CAUSE_VERSION))
    else $error("address byte result carries header fields");

  a_reject_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.kind == KIND_REJECT) |->
      (out_data_o.command_or_fragment == 8'd0 && out_data_o.address_type == 8'd0
       && out_data_o.reserved_field == 16'd0))
    else $error("reject result carries held values");

endmodule

### hdl/shp_in_stage.sv
// ----------------------------------------------------------------------------
// shp_in_stage
// Input register holding one byte transaction until the parser takes it.
// ----------------------------------------------------------------------------
module shp_in_stage
  import shp_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  shp_in_t in_data_i,
  input  logic    take_i,
  output logic    valid_o,
  output shp_in_t data_o
);

  logic    valid_q, valid_d;
  shp_in_t data_q;
  logic    load;

  assign in_stall_o = valid_q && !take_i;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= in_data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

### hdl/shp_core.sv
// ----------------------------------------------------------------------------
// shp_core
// Header phase machine: consumes one byte per take and forms the result.
// ----------------------------------------------------------------------------
module shp_core
  import shp_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cfg_we_i,
  input  logic     cfg_wdata_i,
  input  logic     take_i,
  input  shp_in_t  item_i,
  output shp_res_t res_o
);

  logic       header_kind_q;
  shp_state_t st_q, st_d;
  shp_res_t   res;
  logic       udp;
  logic [7:0] b;
  logic       last;

  assign udp  = (header_kind_q != HDR_REQUEST);
  assign b    = item_i.data_byte;
  assign last = item_i.end_of_packet;

  always_comb begin
    st_d = st_q;
    res  = '0;
    if (st_q.phase == PH_SKIP) begin
      if (last) begin
        st_d = ST_START;
      end
    end else if (st_q.phase == PH_H0 && !udp && b != SocksVersion) begin
      // wrong version
      st_d = ST_START;
      if (!last) begin
        st_d.phase = PH_SKIP;
      end
      res.valid             = 1'b1;
      res.data.kind         = KIND_REJECT;
      res.data.reject_cause = CAUSE_VERSION;
    end else if (st_q.phase == PH_PLO) begin
      res.valid                    = 1'b1;
      res.data.kind                = KIND_ACCEPT;
      res.data.command_or_fragment = st_q.held_command;
      res.data.address_type        = st_q.held_type;
      res.data.address_count       = st_q.addr_count;
      res.data.port_number         = {st_q.port_high, b};
      res.data.reserved_field      = st_q.held_reserved;
      if (last) begin
        st_d = ST_START;
      end else begin
        st_d.phase = PH_SKIP;
      end
    end else if (last) begin
      // early end
      st_d                  = ST_START;
      res.valid             = 1'b1;
      res.data.kind         = KIND_REJECT;
      res.data.reject_cause = CAUSE_EARLY_END;
    end else begin
      unique case (st_q.phase)
        PH_H0: begin
          if (udp) begin
            st_d.held_reserved = {b, 8'd0};
          end
          st_d.phase = PH_H1;
        end
        PH_H1: begin
          if (udp) begin
            st_d.held_reserved = {st_q.held_reserved[15:8], b};
          end else begin
            st_d.held_command = b;
          end
          st_d.phase = PH_H2;
        end
        PH_H2: begin
          if (udp) begin
            st_d.held_command = b;
          end else begin
            st_d.held_reserved = {8'd0, b};
          end
          st_d.phase = PH_TYPE;
        end
        PH_TYPE: begin
          st_d.held_type  = b;
          st_d.addr_count = 8'd0;
          if (b == AtypIpv4) begin
            st_d.addr_remaining = Ipv4Len;
            st_d.phase          = PH_ADDR;
          end else if (b == AtypIpv6) begin
            st_d.addr_remaining = Ipv6Len;
            st_d.phase          = PH_ADDR;
          end else if (b == AtypDomain) begin
            st_d.phase = PH_DLEN;
          end else begin
            st_d.addr_remaining = 8'd0;
            st_d.phase          = PH_PHI;
          end
        end
        PH_DLEN: begin
          st_d.addr_remaining = b;
          st_d.phase          = (b == 8'd0) ? PH_PHI : PH_ADDR;
        end
        PH_ADDR: begin
          st_d.addr_count     = st_q.addr_count + 8'd1;
          st_d.addr_remaining = st_q.addr_remaining - 8'd1;
          if (st_q.addr_remaining == 8'd1) begin
            st_d.phase = PH_PHI;
          end
          res.valid                    = 1'b1;
          res.data.kind                = KIND_ADDR;
          res.data.address_byte        = b;
          res.data.address_index       = st_q.addr_count;
          res.data.command_or_fragment = st_q.held_command;
          res.data.address_type        = st_q.held_type;
          res.data.reserved_field      = st_q.held_reserved;
        end
        PH_PHI: begin
          st_d.port_high = b;
          st_d.phase     = PH_PLO;
        end
        default: begin
          st_d = ST_START;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_kind_q <= HDR_REQUEST;
      st_q          <= ST_START;
    end else begin
      if (cfg_we_i) begin
        header_kind_q <= cfg_wdata_i;
      end
      if (take_i) begin
        st_q <= st_d;
      end
    end
  end

  always_comb begin
    res_o       = res;
    res_o.valid = res.valid && take_i;
  end

endmodule

### hdl/shp_out_stage.sv
// ----------------------------------------------------------------------------
// shp_out_stage
// Result register presenting one result transaction to the downstream side.
// ----------------------------------------------------------------------------
module shp_out_stage
  import shp_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  shp_res_t res_i,
  output logic     ready_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output shp_out_t out_data_o
);

  logic     valid_q, valid_d;
  shp_out_t data_q;

  assign ready_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (ready_o) begin
      valid_d = res_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && res_i.valid) begin
      data_q <= res_i.data;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

### verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for socks_header_parser. A driver feeds packet bytes in
// bursts from a queue filled by the stimulus block, and a monitor checks every
// result against a behavioural parser that runs on each accepted byte. The
// run covers request and datagram headers, all address types, wrong versions,
// early ends, empty addresses, trailing bytes, noise and truncated packets,
// under random stalls and one long output hold-off.
// ----------------------------------------------------------------------------
module testbench;
  import shp_pkg::*;

  localparam int  CycleLimit     = 200000;
  localparam int  DrainCycles    = 6;
  localparam int  RandomPerPhase = 130;
  localparam int  HoldAt         = 300;
  localparam int  HoldCycles     = 400;
  localparam logic HdrDatagram   = 1'b1;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_stall_o;
  shp_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  shp_out_t out_data_o;
  logic     cfg_we_i = 1'b0;
  logic     cfg_wdata_i = 1'b0;

  socks_header_parser uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #10 clk_i = ~clk_i;

  // parser state mirror
  logic        kind_reg;
  phase_e      parse_phase;
  logic [7:0]  addr_left;
  logic [7:0]  addr_seen;
  logic [7:0]  type_held;
  logic [7:0]  cmd_held;
  logic [15:0] rsvd_held;
  logic [7:0]  port_hi;

  shp_in_t     byte_queue[$];
  shp_out_t    header_results[$];
  logic [7:0]  frame[$];

  int cycles = 0;
  int mismatches = 0;
  int bytes_taken = 0;
  int burst_left = 1;
  int gap_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int stall_mode = 0;

  function automatic void clear_header();
    parse_phase = PH_H0;
    addr_left   = '0;
    addr_seen   = '0;
    type_held   = '0;
    cmd_held    = '0;
    rsvd_held   = '0;
    port_hi     = '0;
  endfunction

  function automatic shp_out_t make_result(logic [1:0] kind, logic [7:0] abyte,
                                           logic [7:0] aidx, logic [7:0] alen,
                                           logic [15:0] port, logic cause);
    shp_out_t r;
    r               = '0;
    r.kind          = kind;
    r.address_byte  = abyte;
    r.address_index = aidx;
    r.address_count = alen;
    r.port_number   = port;
    r.reject_cause  = cause;
    if (kind != KIND_REJECT) begin
      r.command_or_fragment = cmd_held;
      r.address_type        = type_held;
      r.reserved_field      = rsvd_held;
    end
    return r;
  endfunction

  function automatic void parse_byte(shp_in_t item);
    logic [7:0] b;
    logic       udp;
    b   = item.data_byte;
    udp = (kind_reg != HDR_REQUEST);
    if (parse_phase == PH_SKIP) begin
      if (item.end_of_packet) clear_header();
    end else if (parse_phase == PH_H0 && !udp && b != SocksVersion) begin
      clear_header();
      if (!item.end_of_packet) parse_phase = PH_SKIP;
      header_results.push_back(make_result(KIND_REJECT, 8'h00, 8'h00, 8'h00, 16'h0000,
                                           CAUSE_VERSION));
    end else if (parse_phase == PH_PLO) begin
      header_results.push_back(make_result(KIND_ACCEPT, 8'h00, 8'h00, addr_seen,
                                           {port_hi, b}, 1'b0));
      if (item.end_of_packet) clear_header();
      else parse_phase = PH_SKIP;
    end else if (item.end_of_packet) begin
      clear_header();
      header_results.push_back(make_result(KIND_REJECT, 8'h00, 8'h00, 8'h00, 16'h0000,
                                           CAUSE_EARLY_END));
    end else begin
      case (parse_phase)
        PH_H0: begin
          if (udp) rsvd_held = {b, 8'h00};
          parse_phase = PH_H1;
        end
        PH_H1: begin
          if (udp) rsvd_held = rsvd_held | {8'h00, b};
          else cmd_held = b;
          parse_phase = PH_H2;
        end
        PH_H2: begin
          if (udp) cmd_held = b;
          else rsvd_held = {8'h00, b};
          parse_phase = PH_TYPE;
        end
        PH_TYPE: begin
          type_held = b;
          addr_seen = '0;
          if (b == AtypIpv4) begin
            addr_left   = Ipv4Len;
            parse_phase = PH_ADDR;
          end else if (b == AtypIpv6) begin
            addr_left   = Ipv6Len;
            parse_phase = PH_ADDR;
          end else if (b == AtypDomain) begin
            parse_phase = PH_DLEN;
          end else begin
            addr_left   = '0;
            parse_phase = PH_PHI;
          end
        end
        PH_DLEN: begin
          addr_left   = b;
          parse_phase = (b == 8'h00) ? PH_PHI : PH_ADDR;
        end
        PH_ADDR: begin
          header_results.push_back(make_result(KIND_ADDR, b, addr_seen, 8'h00, 16'h0000,
                                               1'b0));
          addr_seen = addr_seen + 8'd1;
          addr_left = addr_left - 8'd1;
          if (addr_left == 8'h00) parse_phase = PH_PHI;
        end
        PH_PHI: begin
          port_hi     = b;
          parse_phase = PH_PLO;
        end
        default: clear_header();
      endcase
    end
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycles, what);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  task automatic check_result(input shp_out_t got);
    shp_out_t want;
    if (header_results.size() == 0) begin
      report_mismatch("result with nothing outstanding");
    end else begin
      want = header_results.pop_front();
      check_field("kind", got.kind, want.kind);
      check_field("address_byte", got.address_byte, want.address_byte);
      check_field("address_index", got.address_index, want.address_index);
      check_field("command_or_fragment", got.command_or_fragment,
                  want.command_or_fragment);
      check_field("address_type", got.address_type, want.address_type);
      check_field("address_count", got.address_count, want.address_count);
      check_field("port_number", got.port_number, want.port_number);
      check_field("reserved_field", got.reserved_field, want.reserved_field);
      check_field("reject_cause", got.reject_cause, want.reject_cause);
    end
  endtask

  // driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        parse_byte(in_data_i);
        bytes_taken <= bytes_taken + 1;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left != 0) begin
          gap_left   <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (byte_queue.size() != 0) begin
          in_data_i  <= byte_queue.pop_front();
          in_valid_i <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left   <= ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor and output stall pattern
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) check_result(out_data_o);
      if (hold_left != 0) begin
        hold_left   <= hold_left - 1;
        out_stall_i <= 1'b1;
      end else if (!hold_done && bytes_taken >= HoldAt) begin
        hold_done   <= 1'b1;
        hold_left   <= HoldCycles;
        out_stall_i <= 1'b1;
      end else begin
        if (cycles % 64 == 0) stall_mode <= $urandom_range(3);
        case (stall_mode)
          0:       out_stall_i <= 1'b0;
          1:       out_stall_i <= ($urandom_range(3) == 0);
          2:       out_stall_i <= ($urandom_range(3) != 0);
          default: out_stall_i <= cycles[2];
        endcase
      end
    end
  end

  initial begin
    wait (cycles >= CycleLimit);
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic queue_frame();
    shp_in_t item;
    for (int i = 0; i < frame.size(); i++) begin
      item.data_byte     = frame[i];
      item.end_of_packet = (i == frame.size() - 1);
      byte_queue.push_back(item);
    end
    frame.delete();
  endtask

  task automatic build_frame(input logic udp);
    logic [7:0] atyp;
    int         alen;
    int         sel;
    int         cut;
    frame.delete();
    if (udp) begin
      frame.push_back(8'($urandom_range(255)));
      frame.push_back(8'($urandom_range(255)));
      frame.push_back(8'($urandom_range(255)));
    end else begin
      frame.push_back(8'(($urandom_range(9) == 0) ? $urandom_range(255) : SocksVersion));
      frame.push_back(8'($urandom_range(255)));
      frame.push_back(8'(($urandom_range(3) == 0) ? $urandom_range(255) : 0));
    end
    sel = $urandom_range(9);
    if (sel < 3) atyp = AtypIpv4;
    else if (sel < 6) atyp = AtypDomain;
    else if (sel < 8) atyp = AtypIpv6;
    else atyp = 8'($urandom_range(255));
    frame.push_back(atyp);
    if (atyp == AtypIpv4) begin
      alen = int'(Ipv4Len);
    end else if (atyp == AtypIpv6) begin
      alen = int'(Ipv6Len);
    end else if (atyp == AtypDomain) begin
      alen = ($urandom_range(29) == 0) ? $urandom_range(255) : $urandom_range(6);
      frame.push_back(8'(alen));
    end else begin
      alen = 0;
    end
    repeat (alen) frame.push_back(8'($urandom_range(255)));
    frame.push_back(8'($urandom_range(255)));
    frame.push_back(8'($urandom_range(255)));
    if ($urandom_range(2) == 0)
      repeat ($urandom_range(1, 3)) frame.push_back(8'($urandom_range(255)));
    sel = $urandom_range(9);
    if (sel == 0) begin
      // noise
      frame.delete();
      repeat ($urandom_range(1, 6)) frame.push_back(8'($urandom_range(255)));
    end else if (sel == 1) begin
      // truncated packet
      cut = $urandom_range(1, frame.size() - 1);
      while (frame.size() > cut) void'(frame.pop_back());
    end
  endtask

  task automatic drain();
    do @(negedge clk_i);
    while (byte_queue.size() != 0 || in_valid_i || header_results.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_header_kind(input logic k);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= k;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    kind_reg = k;
  endtask

  initial begin
    int added;
    clear_header();
    kind_reg = HDR_REQUEST;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    set_header_kind(HDR_REQUEST);
    // wrong version on a final byte, then early end on the first byte
    frame = '{8'hFA};
    queue_frame();
    frame = '{SocksVersion};
    queue_frame();
    frame = '{SocksVersion, 8'hFF, 8'hFF, AtypIpv4, 8'hC0, 8'hA8, 8'h00, 8'h01,
              8'hFF, 8'hFF};
    queue_frame();
    // empty domain straight to the port, one trailing byte
    frame = '{SocksVersion, 8'h01, 8'h00, AtypDomain, 8'h00, 8'h12, 8'h34, 8'h55};
    queue_frame();
    drain();

    set_header_kind(HdrDatagram);
    frame = '{8'h00};
    queue_frame();
    frame = '{8'hFF, 8'hFF, 8'h80, AtypDomain, 8'h02, 8'h61, 8'h62, 8'h00, 8'h00};
    queue_frame();
    drain();

    for (int p = 0; p < 4; p++) begin
      set_header_kind(p[0]);
      added = 0;
      while (added < RandomPerPhase) begin
        build_frame(p[0]);
        added += frame.size();
        queue_frame();
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
